/* design/bdms_pkg.sv */
// Shared constants, types and helper functions for the display mode selector.
`default_nettype none

package bdms_pkg;

   localparam logic [15:0] START_MODE   = 16'h0013;
   localparam logic [31:0] START_PIXELS = 32'd64000;
   localparam logic [7:0]  START_DEPTH  = 8'd8;
   localparam logic [15:0] ATTR_MASK    = 16'h0090;
   localparam logic [7:0]  MODEL_PACKED = 8'd4;
   localparam logic [7:0]  MODEL_DIRECT = 8'd6;

   localparam logic [15:0] RESET_TARGET_WIDTH  = 16'd1280;
   localparam logic [15:0] RESET_TARGET_HEIGHT = 16'd800;
   localparam logic [7:0]  RESET_TARGET_DEPTH  = 8'd32;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_DEPTH  = 2'd2;

   // Scored mode as it leaves the input stage
   typedef struct packed {
      logic        eol;
      logic        pass;
      logic        exact;
      logic [15:0] mode;
      logic [8:0]  dep;
      logic [31:0] pix;
   } score_type;

   function automatic logic [31:0] abs_diff32(input logic [31:0] a, input logic [31:0] b);
      abs_diff32 = (a >= b) ? (a - b) : (b - a);
   endfunction

   // Depth above target counts once, below counts double
   function automatic logic [8:0] depth_distance(input logic [7:0] have,
                                                 input logic [7:0] want);
      logic [8:0] below;
      below = {1'b0, want} - {1'b0, have};
      depth_distance = (have >= want) ? {1'b0, have - want} : {below[7:0], 1'b0};
   endfunction

endpackage

`default_nettype wire

/* design/bdms_req_if.sv */
// Request channel carrying one display mode descriptor per transaction.
`default_nettype none

interface bdms_req_if;
   logic        valid;
   logic        ready;
   logic        end_of_list;
   logic [15:0] mode_number;
   logic        query_ok;
   logic [15:0] attributes;
   logic [7:0]  mem_layout;
   logic [15:0] mode_width;
   logic [15:0] mode_height;
   logic [7:0]  mode_depth;

   modport source (output valid, end_of_list, mode_number, query_ok, attributes,
                   mem_layout, mode_width, mode_height, mode_depth,
                   input ready);
   modport sink (input valid, end_of_list, mode_number, query_ok, attributes,
                 mem_layout, mode_width, mode_height, mode_depth,
                 output ready);
endinterface

`default_nettype wire

/* design/bdms_rsp_if.sv */
// Response channel carrying the chosen mode per transaction.
`default_nettype none

interface bdms_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] chosen_mode;

   modport source (output valid, chosen_mode, input ready);
   modport sink (input valid, chosen_mode, output ready);
endinterface

`default_nettype wire

/* design/bdms_front.sv */
// Input register and combinational scoring of one display mode descriptor.
`default_nettype none

module bdms_front import bdms_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   bdms_req_if.sink         req_chan,
   input  wire logic [15:0] target_width,
   input  wire logic [15:0] target_height,
   input  wire logic [7:0]  target_depth,
   input  wire logic [31:0] target_area,
   output logic             score_valid,
   output score_type        score,
   input  wire logic        score_ready
);

   logic        a_valid_ff;
   logic        a_eol_ff;
   logic [15:0] a_mode_ff;
   logic        a_ok_ff;
   logic [15:0] a_attr_ff;
   logic [7:0]  a_model_ff;
   logic [15:0] a_w_ff;
   logic [15:0] a_h_ff;
   logic [7:0]  a_bpp_ff;

   logic        free_a;
   logic [31:0] mode_area;

   // Take a new transaction when the register is empty or its score moves on
   assign free_a         = !a_valid_ff || score_ready;
   assign req_chan.ready = free_a;
   assign score_valid    = a_valid_ff;

   always_comb begin
      mode_area   = {16'd0, a_w_ff} * {16'd0, a_h_ff};
      score       = '0;
      score.eol   = a_eol_ff;
      score.mode  = a_mode_ff;
      score.pass  = a_ok_ff && ((a_attr_ff & ATTR_MASK) == ATTR_MASK) &&
                    (a_model_ff == MODEL_PACKED || a_model_ff == MODEL_DIRECT);
      score.exact = (a_w_ff == target_width) && (a_h_ff == target_height) &&
                    (a_bpp_ff == target_depth);
      score.dep   = depth_distance(a_bpp_ff, target_depth);
      score.pix   = abs_diff32(mode_area, target_area);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (free_a) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free_a && req_chan.valid) begin
         a_eol_ff   <= req_chan.end_of_list;
         a_mode_ff  <= req_chan.mode_number;
         a_ok_ff    <= req_chan.query_ok;
         a_attr_ff  <= req_chan.attributes;
         a_model_ff <= req_chan.mem_layout;
         a_w_ff     <= req_chan.mode_width;
         a_h_ff     <= req_chan.mode_height;
         a_bpp_ff   <= req_chan.mode_depth;
      end
   end

endmodule

`default_nettype wire

/* design/best_display_mode_select_top.sv */
// Top level of the display mode selector: target registers, running best and result register.
`default_nettype none

// Each request transaction carries one mode descriptor; the block takes one per clock
// cycle. A descriptor is held in the input register, then scored and folded into the
// running best in the same cycle that it leaves that register, and any result is
// registered in the result register. A result held by the receiver stalls the input once the input
// register is also full. A list ends with an end-of-list transaction, which returns the
// best mode unless an exact match was already returned for that list. The first
// transaction after reset or after end of list opens a new search starting from mode
// 0x13. Write the target registers only while no list item is in flight.

module best_display_mode_select_top import bdms_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bdms_req_if.sink                        req_chan,
   bdms_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   logic [15:0] target_width_ff;
   logic [15:0] target_height_ff;
   logic [7:0]  target_depth_ff;
   logic [31:0] target_area_ff;
   logic [31:0] start_pix;
   logic [8:0]  start_dep;

   logic        in_search_ff;
   logic        in_search_in;
   logic        match_ff;
   logic        match_in;
   logic [15:0] best_mode_ff;
   logic [15:0] best_mode_in;
   logic [31:0] best_pix_ff;
   logic [31:0] best_pix_in;
   logic [8:0]  best_dep_ff;
   logic [8:0]  best_dep_in;

   logic        rsp_valid_ff;
   logic [15:0] rsp_mode_ff;
   logic        result;
   logic [15:0] result_mode;

   logic        score_valid;
   score_type   score;
   logic        out_free;
   logic        go;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign go       = score_valid && out_free;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.chosen_mode = rsp_mode_ff;

   bdms_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .target_width  (target_width_ff),
      .target_height (target_height_ff),
      .target_depth  (target_depth_ff),
      .target_area   (target_area_ff),
      .score_valid   (score_valid),
      .score         (score),
      .score_ready   (out_free)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         target_width_ff  <= RESET_TARGET_WIDTH;
         target_height_ff <= RESET_TARGET_HEIGHT;
         target_depth_ff  <= RESET_TARGET_DEPTH;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET_WIDTH:  target_width_ff  <= csr_wr_data;
            CSR_TARGET_HEIGHT: target_height_ff <= csr_wr_data;
            CSR_TARGET_DEPTH:  target_depth_ff  <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // Area follows a write in the next cycle
   always_ff @(posedge clock) begin
      target_area_ff <= {16'd0, target_width_ff} * {16'd0, target_height_ff};
   end

   assign start_pix = abs_diff32(START_PIXELS, target_area_ff);
   assign start_dep = depth_distance(START_DEPTH, target_depth_ff);

   always_comb begin
      logic        open_search;
      logic        cur_match;
      logic [15:0] cur_mode;
      logic [31:0] cur_pix;
      logic [8:0]  cur_dep;

      open_search = !in_search_ff;
      cur_match   = open_search ? 1'b0 : match_ff;
      cur_mode    = open_search ? START_MODE : best_mode_ff;
      cur_pix     = open_search ? start_pix : best_pix_ff;
      cur_dep     = open_search ? start_dep : best_dep_ff;

      in_search_in = 1'b1;
      match_in     = cur_match;
      best_mode_in = cur_mode;
      best_pix_in  = cur_pix;
      best_dep_in  = cur_dep;
      result       = 1'b0;
      result_mode  = cur_mode;

      if (score.eol) begin
         in_search_in = 1'b0;
         match_in     = 1'b0;
         result       = !cur_match;
      end else if (cur_match || !score.pass) begin
         // drop: list already answered or mode unusable
      end else if (score.exact) begin
         match_in     = 1'b1;
         best_mode_in = score.mode;
         result       = 1'b1;
         result_mode  = score.mode;
      end else if (cur_pix > score.pix ||
                   (cur_pix == score.pix && cur_dep > score.dep)) begin
         best_mode_in = score.mode;
         best_pix_in  = score.pix;
         best_dep_in  = score.dep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_search_ff <= 1'b0;
         match_ff     <= 1'b0;
         best_mode_ff <= START_MODE;
         best_pix_ff  <= '0;
         best_dep_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            in_search_ff <= in_search_in;
            match_ff     <= match_in;
            best_mode_ff <= best_mode_in;
            best_pix_ff  <= best_pix_in;
            best_dep_ff  <= best_dep_in;
         end
         if (go && result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && result) begin
         rsp_mode_ff <= result_mode;
      end
   end

endmodule

`default_nettype wire

/* sim/bdms_selection_monitor.sv */
`timescale 1ns / 100ps
// Watches the selector's channels, predicts each chosen mode and counts mismatches.
module bdms_selection_monitor import bdms_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bdms_req_if                             req_mon,
   bdms_rsp_if                             rsp_mon,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   output int                              mismatch_count,
   output int                              pending_count
);

   logic [15:0] tgt_width;
   logic [15:0] tgt_height;
   logic [7:0]  tgt_depth;

   bit          searching;
   bit          matched;
   logic [15:0] lead_mode;
   logic [31:0] lead_pix;
   logic [8:0]  lead_dep;

   logic [15:0] expected_modes[$];

   initial mismatch_count = 0;

   function automatic logic [31:0] area_gap(logic [31:0] a, logic [31:0] b);
      if (a >= b) return a - b;
      return b - a;
   endfunction

   // Depth above target costs once, below costs double
   function automatic logic [8:0] depth_gap(logic [7:0] have, logic [7:0] want);
      logic [8:0] short_by;
      if (have >= want) return {1'b0, have} - {1'b0, want};
      short_by = {1'b0, want} - {1'b0, have};
      return short_by << 1;
   endfunction

   task automatic note_mismatch(logic [15:0] want, logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR: chosen_mode expected 0x%h, got 0x%h", want, got);
   endtask

   task automatic check_chosen(logic [15:0] got);
      logic [15:0] want;
      if (expected_modes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: chosen_mode 0x%h arrived with nothing outstanding", got);
         return;
      end
      want = expected_modes.pop_front();
      if (got !== want) note_mismatch(want, got);
   endtask

   // Advance the running search by one accepted descriptor
   task automatic advance_search();
      logic [31:0] want_area;
      logic [31:0] pix;
      logic [8:0]  dep;
      want_area = 32'(tgt_width) * 32'(tgt_height);
      if (!searching) begin
         searching = 1'b1;
         matched   = 1'b0;
         lead_mode = START_MODE;
         lead_pix  = area_gap(START_PIXELS, want_area);
         lead_dep  = depth_gap(START_DEPTH, tgt_depth);
      end
      if (req_mon.end_of_list) begin
         searching = 1'b0;
         if (matched) matched = 1'b0;
         else expected_modes.push_back(lead_mode);
         return;
      end
      if (matched || !req_mon.query_ok) return;
      if ((req_mon.attributes & ATTR_MASK) != ATTR_MASK) return;
      if (req_mon.mem_layout != MODEL_PACKED && req_mon.mem_layout != MODEL_DIRECT) return;
      if (req_mon.mode_width == tgt_width && req_mon.mode_height == tgt_height &&
          req_mon.mode_depth == tgt_depth) begin
         matched   = 1'b1;
         lead_mode = req_mon.mode_number;
         expected_modes.push_back(req_mon.mode_number);
         return;
      end
      pix = area_gap(32'(req_mon.mode_width) * 32'(req_mon.mode_height), want_area);
      dep = depth_gap(req_mon.mode_depth, tgt_depth);
      if (lead_pix > pix || (lead_pix == pix && lead_dep > dep)) begin
         lead_mode = req_mon.mode_number;
         lead_pix  = pix;
         lead_dep  = dep;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tgt_width  = RESET_TARGET_WIDTH;
         tgt_height = RESET_TARGET_HEIGHT;
         tgt_depth  = RESET_TARGET_DEPTH;
         searching  = 1'b0;
         matched    = 1'b0;
         lead_mode  = START_MODE;
         lead_pix   = '0;
         lead_dep   = '0;
         expected_modes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TARGET_WIDTH: tgt_width = csr_wr_data;
               CSR_TARGET_HEIGHT: tgt_height = csr_wr_data;
               CSR_TARGET_DEPTH: tgt_depth = csr_wr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) check_chosen(rsp_mon.chosen_mode);
         if (req_mon.valid && req_mon.ready) advance_search();
      end
      pending_count = expected_modes.size();
   end

endmodule

/* sim/best_display_mode_select_top_test.sv */
`timescale 1ns / 100ps
// Stimulus, handshake pacing and verdict for the display mode selector.
module best_display_mode_select_top_test;
   import bdms_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic        eol;
      logic [15:0] mode;
      logic        ok;
      logic [15:0] attr;
      logic [7:0]  model;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  depth;
   } mode_desc_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   int          mismatch_count;
   int          pending_count;
   int          cycle_count;
   bit          quiet;
   bit          hold_rsp;
   logic [15:0] cur_w;
   logic [15:0] cur_h;
   logic [7:0]  cur_d;

   logic [15:0] common_sizes[12] = '{16'd200, 16'd320, 16'd400, 16'd480, 16'd600, 16'd640,
                                     16'd720, 16'd768, 16'd800, 16'd1024, 16'd1080,
                                     16'd1280};
   logic [7:0]  common_depths[5] = '{8'd8, 8'd15, 8'd16, 8'd24, 8'd32};

   bdms_req_if req_chan();
   bdms_rsp_if rsp_chan();

   best_display_mode_select_top uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   bdms_selection_monitor monitor (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic mode_desc_type make_mode(logic [15:0] num, logic [15:0] w,
                                               logic [15:0] h, logic [7:0] depth);
      mode_desc_type d;
      d.eol   = 1'b0;
      d.mode  = num;
      d.ok    = 1'b1;
      d.attr  = ATTR_MASK;
      d.model = MODEL_DIRECT;
      d.w     = w;
      d.h     = h;
      d.depth = depth;
      return d;
   endfunction

   // Mode fields on a terminator carry nothing, so fill them with noise
   function automatic mode_desc_type make_eol();
      mode_desc_type d;
      d.eol   = 1'b1;
      d.mode  = 16'($urandom);
      d.ok    = 1'($urandom);
      d.attr  = 16'($urandom);
      d.model = 8'($urandom);
      d.w     = 16'($urandom);
      d.h     = 16'($urandom);
      d.depth = 8'($urandom);
      return d;
   endfunction

   function automatic logic [15:0] pick_dim(logic [15:0] t);
      case ($urandom_range(0, 7))
         0, 1: return t;
         2: return t + 16'd1;
         3: return t - 16'd1;
         4, 5: return common_sizes[$urandom_range(0, 11)];
         6: return 16'($urandom);
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   function automatic logic [7:0] pick_depth(logic [7:0] t);
      case ($urandom_range(0, 6))
         0, 1: return t;
         2: return common_depths[$urandom_range(0, 4)];
         3: return t + 8'd1;
         4: return t - 8'd1;
         5: return 8'($urandom);
         default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // Mostly acceptable modes near the target; a fifth are broken in one way or another
   function automatic mode_desc_type random_mode();
      mode_desc_type d;
      d.eol   = 1'b0;
      d.mode  = 16'($urandom);
      d.ok    = 1'b1;
      d.attr  = 16'($urandom) | ATTR_MASK;
      d.model = $urandom_range(0, 1) ? MODEL_PACKED : MODEL_DIRECT;
      if ($urandom_range(0, 15) == 0) begin
         d.w     = cur_w;
         d.h     = cur_h;
         d.depth = cur_d;
      end else begin
         d.w     = pick_dim(cur_w);
         d.h     = pick_dim(cur_h);
         d.depth = pick_depth(cur_d);
      end
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0: d.ok = 1'b0;
            1: d.attr = 16'($urandom);
            2: d.model = 8'($urandom);
            default: begin
               d.ok    = 1'($urandom);
               d.attr  = 16'($urandom);
               d.model = 8'($urandom);
               d.w     = 16'($urandom);
               d.h     = 16'($urandom);
               d.depth = 8'($urandom);
            end
         endcase
      end
      return d;
   endfunction

   // Enter and leave on a rising edge; valid is only lowered when a gap is drawn
   task automatic send_desc(mode_desc_type d);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.end_of_list  <= d.eol;
      req_chan.mode_number  <= d.mode;
      req_chan.query_ok     <= d.ok;
      req_chan.attributes   <= d.attr;
      req_chan.mem_layout   <= d.model;
      req_chan.mode_width   <= d.w;
      req_chan.mode_height  <= d.h;
      req_chan.mode_depth   <= d.depth;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Let the pipeline empty, including transactions that produce no result
   task automatic drain();
      req_chan.valid <= 1'b0;
      repeat (6) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_target(logic [15:0] w, logic [15:0] h, logic [7:0] depth);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_TARGET_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index   <= CSR_TARGET_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      csr_index   <= CSR_TARGET_DEPTH;
      csr_wr_data <= CSR_DATA_WIDTH'(depth);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_w = w;
      cur_h = h;
      cur_d = depth;
   endtask

   task automatic run_phase(logic [15:0] w, logic [15:0] h, logic [7:0] depth, int budget);
      int sent;
      int len;
      write_target(w, h, depth);
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 9))
            0: len = 0;
            1: len = $urandom_range(20, 40);
            default: len = $urandom_range(1, 10);
         endcase
         quiet = ($urandom_range(0, 7) == 0);
         repeat (len) send_desc(random_mode());
         send_desc(make_eol());
         sent += len + 1;
      end
      quiet = 1'b0;
      drain();
   endtask

   // Short lists give a result almost every transaction; with the receiver held off
   // the block must back up and stall its input
   task automatic back_pressure();
      hold_rsp = 1'b1;
      quiet    = 1'b1;
      repeat (30) begin
         if ($urandom_range(0, 1)) send_desc(random_mode());
         send_desc(make_eol());
      end
      quiet = 1'b0;
      drain();
   endtask

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            stall    = 300;
            hold_rsp = 1'b0;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 5);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      mode_desc_type m;
      quiet    = 1'b0;
      hold_rsp = 1'b0;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_TARGET_WIDTH;
      csr_wr_data           <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.end_of_list  <= 1'b0;
      req_chan.mode_number  <= '0;
      req_chan.query_ok     <= 1'b0;
      req_chan.attributes   <= '0;
      req_chan.mem_layout   <= '0;
      req_chan.mode_width   <= '0;
      req_chan.mode_height  <= '0;
      req_chan.mode_depth   <= '0;
      cur_w = RESET_TARGET_WIDTH;
      cur_h = RESET_TARGET_HEIGHT;
      cur_d = RESET_TARGET_DEPTH;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty list straight after reset
      send_desc(make_eol());

      // Every rejection reason on an otherwise perfect mode, then pixel and depth ties
      m = make_mode(16'h0101, 1280, 800, 32); m.ok = 1'b0; send_desc(m);
      m = make_mode(16'h0102, 1280, 800, 32); m.attr = 16'hFF7F; send_desc(m);
      m = make_mode(16'h0103, 1280, 800, 32); m.attr = 16'hFFEF; send_desc(m);
      m = make_mode(16'h0104, 1280, 800, 32); m.model = 8'd5; send_desc(m);
      m = make_mode(16'h0105, 1024, 768, 32); m.model = MODEL_PACKED; send_desc(m);
      send_desc(make_mode(16'h0106, 1280, 1024, 16));
      send_desc(make_mode(16'h0107, 1024, 1000, 32));
      send_desc(make_mode(16'h0108, 1000, 1024, 32));
      send_desc(make_mode(16'h0109, 1024, 1000, 16));
      send_desc(make_eol());

      // Near misses on depth, then an exact match, after which everything up to the terminator is ignored
      send_desc(make_mode(16'h0140, 1280, 800, 40));
      send_desc(make_mode(16'h0141, 1280, 800, 24));
      send_desc(make_mode(16'h0142, 1280, 800, 32));
      send_desc(make_mode(16'h0143, 1280, 800, 32));
      send_desc(make_eol());

      // Field extremes
      m = make_mode(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF); m.attr = 16'hFFFF; send_desc(m);
      m = make_mode(16'h0000, 16'h0000, 16'h0000, 8'h00); m.model = MODEL_PACKED; send_desc(m);
      m = '1; send_desc(m);
      drain();

      // Targets change while a list is open
      send_desc(make_mode(16'h0201, 640, 480, 8));
      drain();
      write_target(640, 480, 16);
      send_desc(make_mode(16'h0202, 640, 480, 8));
      send_desc(make_mode(16'h0203, 800, 600, 16));
      send_desc(make_eol());
      drain();

      // Zero targets
      write_target(0, 0, 0);
      send_desc(make_mode(16'h0301, 0, 0, 0));
      send_desc(make_eol());
      drain();

      run_phase(RESET_TARGET_WIDTH, RESET_TARGET_HEIGHT, RESET_TARGET_DEPTH, 250);
      back_pressure();
      run_phase(16'h0000, 16'h0000, 8'h00, 250);
      run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 250);
      run_phase(640, 480, 8, 250);
      run_phase(320, 200, 8, 250);
      run_phase(16'($urandom), 16'($urandom), 8'($urandom), 250);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/bdms_pkg.sv
design/bdms_req_if.sv
design/bdms_rsp_if.sv
design/bdms_front.sv
design/best_display_mode_select_top.sv
sim/bdms_selection_monitor.sv
sim/best_display_mode_select_top_test.sv
